FILE: rtl/usci_pkg.sv
`default_nettype none

package usci_pkg;

    // Receive queue size and frame length in bit times
    localparam int RX_QUEUE_DEPTH = 16;
    localparam int FRAME_BITS     = 10;

    localparam int QIDX_W  = (RX_QUEUE_DEPTH > 1) ? $clog2(RX_QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(RX_QUEUE_DEPTH + 1);
    localparam int TIMER_W = 16;

    // Status/control bit positions
    localparam int SC_TE   = 1;
    localparam int SC_TIE  = 2;
    localparam int SC_RE   = 3;
    localparam int SC_RIE  = 4;
    localparam int SC_TDRE = 5;
    localparam int SC_RDRF = 7;

    localparam logic [7:0] SC_RESET     = 8'h20;
    localparam logic [7:0] SC_KEEP_MASK = 8'he0;
    localparam logic [7:0] SC_WR_MASK   = 8'h1f;
    localparam logic [3:0] RATE_MASK    = 4'hf;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_LINE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OFF_RATE   = 2'd0,
        OFF_STATUS = 2'd1,
        OFF_RXDATA = 2'd2,
        OFF_TXDATA = 2'd3
    } reg_off_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } rxq_ctl_t;

    typedef struct packed {
        logic [7:0]        head_data;
        logic [QCNT_W-1:0] count;
        logic              empty;
        logic              full;
    } rxq_stat_t;

    // Frame length in ticks for a given rate select
    function automatic logic [TIMER_W-1:0] frame_ticks(input logic [1:0] sel);
        logic [TIMER_W-1:0] t;
        case (sel)
            2'd0:    t = TIMER_W'(16 * FRAME_BITS);
            2'd1:    t = TIMER_W'(128 * FRAME_BITS);
            2'd2:    t = TIMER_W'(1024 * FRAME_BITS);
            default: t = TIMER_W'(4096 * FRAME_BITS);
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/usci_rx_queue.sv
`default_nettype none

// Circular receive queue; one push, pop or clear per cycle.
module usci_rx_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire usci_pkg::rxq_ctl_t  ctl,
    input  wire logic [7:0]          push_data,
    output usci_pkg::rxq_stat_t      stat
);

    logic [7:0]                   mem [usci_pkg::RX_QUEUE_DEPTH];
    logic [usci_pkg::QIDX_W-1:0]  head_reg, head_next;
    logic [usci_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic [usci_pkg::QIDX_W:0]    tail_sum;
    logic [usci_pkg::QIDX_W-1:0]  tail;
    logic                         full;
    logic                         push_ok;
    logic [7:0]                   head_data_reg;

    assign full     = (count_reg == usci_pkg::QCNT_W'(usci_pkg::RX_QUEUE_DEPTH));
    assign tail_sum = {1'b0, head_reg} + (usci_pkg::QIDX_W + 1)'(count_reg);
    assign push_ok  = ctl.push && !ctl.clear && !full;

    always_comb
    begin
        if (tail_sum >= (usci_pkg::QIDX_W + 1)'(usci_pkg::RX_QUEUE_DEPTH))
        begin
            tail = usci_pkg::QIDX_W'(tail_sum
                   - (usci_pkg::QIDX_W + 1)'(usci_pkg::RX_QUEUE_DEPTH));
        end
        else
        begin
            tail = tail_sum[usci_pkg::QIDX_W-1:0];
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctl.clear)
        begin
            head_next  = '0;
            count_next = '0;
        end
        else if (ctl.pop && count_reg != '0)
        begin
            if (head_reg == usci_pkg::QIDX_W'(usci_pkg::RX_QUEUE_DEPTH - 1))
            begin
                head_next = '0;
            end
            else
            begin
                head_next = head_reg + 1'b1;
            end
            count_next = count_reg - 1'b1;
        end
        else if (ctl.push && !full)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // storage, no reset: entries are read only after being written.
    // The head entry is registered from the next head pointer; a push into an empty
    // queue goes straight to the head register.
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[tail] <= push_data;
        end
        if (push_ok && tail == head_next)
        begin
            head_data_reg <= push_data;
        end
        else
        begin
            head_data_reg <= mem[head_next];
        end
    end

    assign stat.head_data = head_data_reg;
    assign stat.count     = count_reg;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = full;

endmodule

`default_nettype wire

FILE: rtl/uart_sci_register_model.sv
`default_nettype none

// Channel    | Signals                                   | Direction | Handshake
// -----------+-------------------------------------------+-----------+------------------
// request    | cmd, bus_address, data_byte               | in        | start && !busy
// result     | read_data, tx_valid, tx_byte, tx_irq,     | out       | done, one cycle
//            | rx_irq, bad_address, rx_dropped           |           |
// config     | cfg_data (register block base)            | in        | cfg_write
//
// One request per cycle; busy is never raised. A request is registered at
// the accepting edge, processed from the request register, and its result
// is shown with done from the result register. Processing is a single
// register-to-register pass through the timer, queue and status update
// logic.
// rst_n is asynchronous, active low: status returns to 0x20 (transmit
// empty), timers, pending bits and queue pointers clear.
// The receiver cannot stall; each result is valid exactly for the done cycle.
module uart_sci_register_model (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  cmd,
    input  wire logic [15:0] bus_address,
    input  wire logic [7:0]  data_byte,
    input  wire logic        cfg_write,
    input  wire logic [15:0] cfg_data,
    output logic             done,
    output logic [7:0]       read_data,
    output logic             tx_valid,
    output logic [7:0]       tx_byte,
    output logic             tx_irq,
    output logic             rx_irq,
    output logic             bad_address,
    output logic             rx_dropped
);

    // Request register
    logic                  req_valid_reg;
    usci_pkg::cmd_t        cmd_reg;
    logic [15:0]           addr_reg;
    logic [7:0]            data_reg;

    // Configuration
    logic [15:0]           base_reg;

    // Architectural state
    logic [3:0]                     rate_reg, rate_next;
    logic [7:0]                     sc_reg, sc_next;
    logic [7:0]                     rdata_reg, rdata_next;
    logic [usci_pkg::TIMER_W-1:0]   tx_timer_reg, tx_timer_next;
    logic [usci_pkg::TIMER_W-1:0]   rx_timer_reg, rx_timer_next;
    logic                           tx_pend_reg, tx_pend_next;
    logic                           rx_pend_reg, rx_pend_next;

    // Result register
    logic                  done_reg;
    logic [7:0]            rd_reg, rd_next;
    logic                  txv_reg, txv_next;
    logic [7:0]            txb_reg, txb_next;
    logic                  bad_reg, bad_next;
    logic                  drop_reg, drop_next;

    // Work signals
    logic [15:0]                    offset;
    logic                           off_bad;
    logic [usci_pkg::TIMER_W-1:0]   tx_dec, rx_dec;
    logic [usci_pkg::TIMER_W-1:0]   frame_len;
    usci_pkg::rxq_ctl_t             q_ctl;
    usci_pkg::rxq_stat_t            q_stat;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg  <= usci_pkg::cmd_t'(cmd);
            addr_reg <= bus_address;
            data_reg <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_write)
        begin
            base_reg <= cfg_data;
        end
    end

    usci_rx_queue u_rxq (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (q_ctl),
        .push_data (data_reg),
        .stat      (q_stat)
    );

    // offset wraps modulo 2^16; anything past the four registers is bad
    assign offset    = addr_reg - base_reg;
    assign off_bad   = |offset[15:2];
    assign frame_len = usci_pkg::frame_ticks(rate_reg[1:0]);
    assign tx_dec    = (tx_timer_reg != '0) ? tx_timer_reg - 1'b1 : tx_timer_reg;
    assign rx_dec    = (rx_timer_reg != '0) ? rx_timer_reg - 1'b1 : rx_timer_reg;

    always_comb
    begin
        rate_next     = rate_reg;
        sc_next       = sc_reg;
        rdata_next    = rdata_reg;
        tx_timer_next = tx_timer_reg;
        rx_timer_next = rx_timer_reg;
        tx_pend_next  = tx_pend_reg;
        rx_pend_next  = rx_pend_reg;
        q_ctl         = '0;
        rd_next       = '0;
        txv_next      = 1'b0;
        txb_next      = '0;
        bad_next      = 1'b0;
        drop_next     = 1'b0;

        if (req_valid_reg)
        begin
            case (cmd_reg)
                usci_pkg::CMD_TICK:
                begin
                    // transmit frame timer
                    tx_timer_next = tx_dec;
                    if (tx_timer_reg != '0 && tx_dec == '0)
                    begin
                        sc_next[usci_pkg::SC_TDRE] = 1'b1;
                        if (sc_reg[usci_pkg::SC_TIE])
                        begin
                            tx_pend_next = 1'b1;
                        end
                    end
                    // receive frame timer; an idle receiver takes the next byte
                    rx_timer_next = rx_dec;
                    if (rx_dec == '0 && !q_stat.empty)
                    begin
                        q_ctl.pop                  = 1'b1;
                        rdata_next                 = q_stat.head_data;
                        sc_next[usci_pkg::SC_RDRF] = 1'b1;
                        if (sc_reg[usci_pkg::SC_RIE])
                        begin
                            rx_pend_next = 1'b1;
                        end
                        rx_timer_next = frame_len;
                    end
                end
                usci_pkg::CMD_LINE:
                begin
                    if (q_stat.full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        q_ctl.push = 1'b1;
                    end
                end
                usci_pkg::CMD_WRITE:
                begin
                    if (off_bad)
                    begin
                        bad_next = 1'b1;
                    end
                    else
                    begin
                        case (usci_pkg::reg_off_t'(offset[1:0]))
                            usci_pkg::OFF_RATE:
                            begin
                                rate_next = data_reg[3:0] & usci_pkg::RATE_MASK;
                            end
                            usci_pkg::OFF_STATUS:
                            begin
                                sc_next = (sc_reg & usci_pkg::SC_KEEP_MASK)
                                        | (data_reg & usci_pkg::SC_WR_MASK);
                                // receive enable turning on flushes the queue
                                if (!sc_reg[usci_pkg::SC_RE] && data_reg[usci_pkg::SC_RE])
                                begin
                                    q_ctl.clear = 1'b1;
                                end
                            end
                            usci_pkg::OFF_TXDATA:
                            begin
                                if (sc_reg[usci_pkg::SC_TIE])
                                begin
                                    tx_pend_next = 1'b0;
                                end
                                if (sc_reg[usci_pkg::SC_TE] && sc_reg[usci_pkg::SC_TDRE])
                                begin
                                    sc_next[usci_pkg::SC_TDRE] = 1'b0;
                                    txv_next      = 1'b1;
                                    txb_next      = data_reg;
                                    tx_timer_next = frame_len;
                                end
                            end
                            default:
                            begin
                                // receive data register is read only
                            end
                        endcase
                    end
                end
                default:
                begin
                    // bus read
                    if (off_bad)
                    begin
                        bad_next = 1'b1;
                    end
                    else
                    begin
                        case (usci_pkg::reg_off_t'(offset[1:0]))
                            usci_pkg::OFF_STATUS:
                            begin
                                rd_next = sc_reg;
                            end
                            usci_pkg::OFF_RXDATA:
                            begin
                                rd_next      = rdata_reg;
                                rx_pend_next = 1'b0;
                            end
                            default:
                            begin
                                // write-only registers read as zero
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg     <= '0;
            sc_reg       <= usci_pkg::SC_RESET;
            rdata_reg    <= '0;
            tx_timer_reg <= '0;
            rx_timer_reg <= '0;
            tx_pend_reg  <= 1'b0;
            rx_pend_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            rate_reg     <= rate_next;
            sc_reg       <= sc_next;
            rdata_reg    <= rdata_next;
            tx_timer_reg <= tx_timer_next;
            rx_timer_reg <= rx_timer_next;
            tx_pend_reg  <= tx_pend_next;
            rx_pend_reg  <= rx_pend_next;
            done_reg     <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg   <= rd_next;
        txv_reg  <= txv_next;
        txb_reg  <= txb_next;
        bad_reg  <= bad_next;
        drop_reg <= drop_next;
    end

    // pending bits already hold the post-request value during done
    assign done        = done_reg;
    assign read_data   = rd_reg;
    assign tx_valid    = txv_reg;
    assign tx_byte     = txb_reg;
    assign tx_irq      = tx_pend_reg;
    assign rx_irq      = rx_pend_reg;
    assign bad_address = bad_reg;
    assign rx_dropped  = drop_reg;

    // A started frame leaves transmit empty clear and the timer running
    a_tx_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (done && tx_valid) |-> (!sc_reg[usci_pkg::SC_TDRE] && tx_timer_reg != '0))
        else $error("tx frame start did not load timer / clear TDRE");

    // Queue occupancy never passes its depth
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= usci_pkg::QCNT_W'(usci_pkg::RX_QUEUE_DEPTH))
        else $error("receive queue overfilled");

    // A dropped byte means the queue was full and stays full
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rx_dropped) |-> q_stat.full)
        else $error("byte dropped with room in queue");

    // Bad access never starts a transmit or returns data
    a_bad_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_address) |-> (!tx_valid && read_data == '0))
        else $error("bad address access had side effects");

    // Each accepted request is followed by its done strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("result strobe missing");

endmodule

`default_nettype wire
